// ===== rtl/fixed_to_decimal_text_core_defines.svh =====
// Assertion macros shared by the fixed-to-decimal text core.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef FIXED_TO_DECIMAL_TEXT_CORE_DEFINES_SVH
`define FIXED_TO_DECIMAL_TEXT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define FTDT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fixed_to_decimal_text_core: assertion failed");
// checked property, also active during reset
`define FTDT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fixed_to_decimal_text_core: assertion failed");
`else
`define FTDT_ASSERT(lbl, clk, rst_n, prop)
`define FTDT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/ftdt_pkg.sv =====
// Shared types and constants of the fixed-to-decimal text core.
// No dependencies; used by ftdt_ctrl, ftdt_datapath and the top level.
package ftdt_pkg;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_POINT = 7'h2E;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    // which character the output register captures
    typedef enum logic [1:0] {
        SEL_MINUS = 2'd0,
        SEL_INT   = 2'd1,
        SEL_POINT = 2'd2,
        SEL_FRAC  = 2'd3
    } char_sel_t;

    typedef struct packed {
        logic      load;       // capture a new input value
        logic      conv_step;  // one double-dabble step
        logic      int_shift;  // drop the top integer digit
        logic      frac_step;  // multiply fraction by ten
        logic      out_load;   // write the output register
        char_sel_t sel;
        logic      last;
    } ftdt_cmd_t;

    typedef struct packed {
        logic neg;           // value was negative
        logic int_digit_nz;  // top integer BCD digit is nonzero
        logic out_free;      // output register can take a character
    } ftdt_status_t;

endpackage

// ===== rtl/ftdt_datapath.sv =====
// Datapath of the fixed-to-decimal text core: magnitude, BCD conversion,
// fraction digit generation and the output register. Uses ftdt_pkg.
module ftdt_datapath #(
    parameter int INT_BITS   = 32,
    parameter int FRAC_BITS  = 32,
    parameter int INT_DIGITS = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [63:0]      value,
    input  ftdt_pkg::ftdt_cmd_t     cmd,
    output ftdt_pkg::ftdt_status_t  stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [6:0]              character,
    output logic                    last
);

    localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;
    localparam int BCD_BITS   = 4 * INT_DIGITS;

    logic [TOTAL_BITS-1:0] raw;
    logic [TOTAL_BITS-1:0] mag;
    logic                  raw_neg;

    logic [INT_BITS-1:0]   bin_reg,  bin_next;
    logic [BCD_BITS-1:0]   bcd_reg,  bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [FRAC_BITS-1:0]  frac_reg, frac_next;
    logic                  neg_reg,  neg_next;
    logic [FRAC_BITS+3:0]  frac_x10;
    logic [3:0]            frac_digit;
    logic [3:0]            int_digit;

    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;
    logic                  out_free;

    assign raw     = value[TOTAL_BITS-1:0];
    assign raw_neg = raw[TOTAL_BITS-1];
    assign mag     = raw_neg ? (~raw + TOTAL_BITS'(1)) : raw;

    // add-3 correction on every BCD digit before the shift
    always_comb
    begin
        logic [3:0] dig;
        for (int d = 0; d < INT_DIGITS; d++)
        begin
            dig = bcd_reg[4*d +: 4];
            bcd_adj[4*d +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
        end
    end

    assign frac_x10   = ({4'b0, frac_reg} << 3) + ({4'b0, frac_reg} << 1);
    assign frac_digit = frac_x10[FRAC_BITS+3:FRAC_BITS];
    assign int_digit  = bcd_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        frac_next = frac_reg;
        neg_next  = neg_reg;
        if (cmd.load)
        begin
            bin_next  = mag[TOTAL_BITS-1:FRAC_BITS];
            bcd_next  = '0;
            frac_next = mag[FRAC_BITS-1:0];
            neg_next  = raw_neg;
        end
        else
        begin
            if (cmd.conv_step)
            begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[INT_BITS-1]};
                bin_next = {bin_reg[INT_BITS-2:0], 1'b0};
            end
            if (cmd.int_shift)
            begin
                bcd_next = {bcd_reg[BCD_BITS-5:0], 4'b0};
            end
            if (cmd.frac_step)
            begin
                frac_next = frac_x10[FRAC_BITS-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.sel)
            ftdt_pkg::SEL_MINUS: char_next = ftdt_pkg::CHAR_MINUS;
            ftdt_pkg::SEL_INT:   char_next = ftdt_pkg::CHAR_ZERO + {3'b0, int_digit};
            ftdt_pkg::SEL_POINT: char_next = ftdt_pkg::CHAR_POINT;
            ftdt_pkg::SEL_FRAC:  char_next = ftdt_pkg::CHAR_ZERO + {3'b0, frac_digit};
            default:             char_next = ftdt_pkg::CHAR_POINT;
        endcase
        last_next = cmd.last;
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        frac_reg <= frac_next;
        neg_reg  <= neg_next;
        if (cmd.out_load)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

    assign stat.neg          = neg_reg;
    assign stat.int_digit_nz = (int_digit != 4'd0);
    assign stat.out_free     = out_free;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/ftdt_ctrl.sv =====
// Controller of the fixed-to-decimal text core: sequences conversion and
// character emission. Uses ftdt_pkg and fixed_to_decimal_text_core_defines.svh.
`include "fixed_to_decimal_text_core_defines.svh"

module ftdt_ctrl #(
    parameter int INT_BITS        = 32,
    parameter int INT_DIGITS      = 10,
    parameter int FRACTION_DIGITS = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output ftdt_pkg::ftdt_cmd_t    cmd,
    input  ftdt_pkg::ftdt_status_t stat
);

    localparam int CNT_MAX = (INT_BITS > FRACTION_DIGITS) ? INT_BITS : FRACTION_DIGITS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CONV  = 6'b000010,
        ST_SIGN  = 6'b000100,
        ST_INT   = 6'b001000,
        ST_POINT = 6'b010000,
        ST_FRAC  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             seen_reg,  seen_next;
    logic             cnt_zero;

    assign cnt_zero = (cnt_reg == '0);
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        seen_next     = seen_reg;
        cmd           = '0;
        cmd.sel       = ftdt_pkg::SEL_POINT;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    seen_next  = 1'b0;
                    cnt_next   = CNT_W'(INT_BITS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (cnt_zero)
                begin
                    cnt_next   = CNT_W'(INT_DIGITS - 1);
                    state_next = stat.neg ? ST_SIGN : ST_INT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SIGN:
            begin
                cmd.sel = ftdt_pkg::SEL_MINUS;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_INT;
                end
            end
            ST_INT:
            begin
                cmd.sel = ftdt_pkg::SEL_INT;
                if (stat.out_free)
                begin
                    cmd.int_shift = 1'b1;
                    // leading zeros are dropped, but the ones digit always goes out
                    cmd.out_load  = stat.int_digit_nz || seen_reg || cnt_zero;
                    seen_next     = seen_reg || stat.int_digit_nz;
                    if (cnt_zero)
                        state_next = ST_POINT;
                    else
                        cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_POINT:
            begin
                cmd.sel = ftdt_pkg::SEL_POINT;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cnt_next     = CNT_W'(FRACTION_DIGITS - 1);
                    state_next   = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                cmd.sel = ftdt_pkg::SEL_FRAC;
                if (stat.out_free)
                begin
                    cmd.frac_step = 1'b1;
                    cmd.out_load  = 1'b1;
                    cmd.last      = cnt_zero;
                    if (cnt_zero)
                        state_next = ST_IDLE;
                    else
                        cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            seen_reg  <= seen_next;
        end
    end

    `FTDT_ASSERT(a_load_when_free, clk, rst_n, cmd.out_load |-> stat.out_free)
    `FTDT_ASSERT(a_accept_starts_conv, clk, rst_n, (in_valid && in_ready) |=> (state_reg == ST_CONV))
    `FTDT_ASSERT(a_last_ends_item, clk, rst_n, (cmd.out_load && cmd.last) |=> (state_reg == ST_IDLE))
    `FTDT_ASSERT(a_conv_exit, clk, rst_n, (state_reg == ST_CONV && cnt_zero) |=> (state_reg == ST_SIGN || state_reg == ST_INT))

endmodule

// ===== rtl/fixed_to_decimal_text_core.sv =====
// Fixed-point to decimal ASCII text converter, top level.
// Input channel (in_valid/in_ready, value) takes one signed fixed-point number
// with INT_BITS integer and FRAC_BITS fraction bits in the low bits of value.
// Output channel (out_valid/out_ready, character, last) gives its text one
// character per transfer: optional '-', integer digits without leading zeros,
// '.', then FRACTION_DIGITS truncated fraction digits; last marks the end.
// After a number is taken, shift-and-add-3 BCD conversion runs one step per
// integer bit, then characters leave at one per cycle while the receiver does
// not stall: the integer digits scan all INT_DIGITS BCD positions one per
// cycle whether printed or not. For a positive number each skipped leading
// zero delays the first character.
// in_ready is high only while no number is in progress; the next number can
// be taken while the final character still waits in the output register.
// A stalled receiver holds the output register and the character states.
// Reset empties the output register and returns the sequencer to idle.
module fixed_to_decimal_text_core #(
    parameter int FRACTION_DIGITS = 6,
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         character,
    output logic               last
);

    // decimal digits of the largest INT_BITS-bit magnitude (0.30103 ~ log10 2)
    localparam int INT_DIGITS = (INT_BITS * 30103) / 100000 + 1;

    ftdt_pkg::ftdt_cmd_t    cmd;
    ftdt_pkg::ftdt_status_t stat;

    ftdt_ctrl #(
        .INT_BITS        (INT_BITS),
        .INT_DIGITS      (INT_DIGITS),
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ftdt_datapath #(
        .INT_BITS   (INT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .INT_DIGITS (INT_DIGITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

endmodule
